// File: src/assert_macros.svh
// Assertion helpers used by the RTL controller (brmb_ctrl).
// Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/brmb_pkg.sv
package brmb_pkg;

    localparam int WINDOW_BITS_DEF = 16;

    // One mark word covers one chunk, one bit per byte.
    localparam int CHUNK_BYTES = 32;
    localparam int CHUNK_SHIFT = 5;
    localparam int OFF_W       = CHUNK_SHIFT;
    localparam int TAKE_W      = CHUNK_SHIFT + 1;

    localparam int ADDR_W      = 16;
    localparam int COUNT_W     = 7;
    localparam int CMD_W       = 2;
    localparam int MAX_SPAN    = 64;

    localparam logic [CMD_W-1:0] CMD_MARK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNMARK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // Controller -> datapath
    typedef struct packed {
        logic start;     // load a new request
        logic clr_wr;    // clearing pass: zero one word
        logic rd;        // read the current chunk's word
        logic wr_chunk;  // modify/write or test the current chunk, advance
        logic load_res;  // move the result into the output register
    } ctl_t;

    // Datapath -> controller
    typedef struct packed {
        logic skip;        // request touches no word
        logic clr_last;    // clearing pass at the last word
        logic last_chunk;  // current chunk finishes the range
    } sts_t;

endpackage

// File: src/brmb_datapath.sv
module brmb_datapath
    import brmb_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CMD_W-1:0]   command,
    input  logic [ADDR_W-1:0]  address,
    input  logic [COUNT_W-1:0] byte_count,
    input  ctl_t               ctl,
    output sts_t               sts,
    output logic               any_marked,
    output logic [CMD_W-1:0]   done_command
);

    localparam int IDX_W = WINDOW_BITS - CHUNK_SHIFT;
    localparam int DEPTH = 1 << IDX_W;

    logic [CHUNK_BYTES-1:0] mem [DEPTH];

    logic [CMD_W-1:0]       cmd_reg;
    logic [WINDOW_BITS-1:0] pos_reg;
    logic [COUNT_W-1:0]     rem_reg;
    logic                   hit_reg;
    logic [CHUNK_BYTES-1:0] rdata_reg;
    logic [IDX_W-1:0]       clr_idx_reg;
    logic                   any_marked_reg;
    logic [CMD_W-1:0]       done_command_reg;

    logic [IDX_W-1:0]       idx;
    logic [OFF_W-1:0]       off;
    logic [TAKE_W-1:0]      chunk_left;
    logic [TAKE_W-1:0]      take;
    logic [CHUNK_BYTES:0]   ones;
    logic [CHUNK_BYTES-1:0] mask;
    logic [CHUNK_BYTES-1:0] wdata;
    logic                   we;
    logic [COUNT_W-1:0]     count_sat;

    assign idx        = pos_reg[WINDOW_BITS-1:CHUNK_SHIFT];
    assign off        = pos_reg[OFF_W-1:0];
    assign chunk_left = TAKE_W'(CHUNK_BYTES) - {1'b0, off};
    assign take       = (rem_reg < COUNT_W'(chunk_left)) ? TAKE_W'(rem_reg) : chunk_left;
    assign ones       = ((CHUNK_BYTES+1)'(1) << take) - (CHUNK_BYTES+1)'(1);
    assign mask       = ones[CHUNK_BYTES-1:0] << off;
    assign wdata      = (cmd_reg == CMD_MARK) ? (rdata_reg | mask) : (rdata_reg & ~mask);
    assign we         = ctl.wr_chunk && (cmd_reg == CMD_MARK || cmd_reg == CMD_UNMARK);
    assign count_sat  = (byte_count > COUNT_W'(MAX_SPAN)) ? COUNT_W'(MAX_SPAN) : byte_count;

    assign sts.skip       = (command == CMD_NONE) || (byte_count == '0);
    assign sts.clr_last   = (clr_idx_reg == '1);
    assign sts.last_chunk = (COUNT_W'(take) == rem_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.clr_wr)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (we)
        begin
            mem[idx] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (ctl.clr_wr)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg <= command;
            pos_reg <= WINDOW_BITS'(address);
            rem_reg <= count_sat;
            hit_reg <= 1'b0;
        end
        else if (ctl.wr_chunk)
        begin
            // window is whole chunks, so the add wraps at the window top
            pos_reg <= pos_reg + WINDOW_BITS'(take);
            rem_reg <= rem_reg - COUNT_W'(take);
            hit_reg <= hit_reg | (|(rdata_reg & mask));
        end
        if (ctl.load_res)
        begin
            any_marked_reg   <= (cmd_reg == CMD_TEST) && hit_reg;
            done_command_reg <= cmd_reg;
        end
    end

    assign any_marked   = any_marked_reg;
    assign done_command = done_command_reg;

endmodule

// File: src/brmb_ctrl.sv
module brmb_ctrl
    import brmb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output ctl_t ctl
);

    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_WR    = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       res_free;

    assign res_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = sts.skip ? ST_FIN : ST_RD;
                end
            end
            ST_RD:
            begin
                ctl.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                ctl.wr_chunk = 1'b1;
                state_next   = sts.last_chunk ? ST_FIN : ST_RD;
            end
            ST_FIN:
            begin
                if (res_free)
                begin
                    ctl.load_res = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `ASSERT_IMPL(a_no_accept_in_clear, state_reg == ST_CLEAR, in_stall)
    `ASSERT_IMPL(a_load_only_free, ctl.load_res, !(out_valid_reg && out_stall))
    `ASSERT_NEXT(a_last_to_fin, state_reg == ST_WR && sts.last_chunk, state_reg == ST_FIN)
    `ASSERT_NEXT(a_load_sets_valid, ctl.load_res, out_valid_reg)

endmodule

// File: src/byte_range_mark_bitmap_top.sv
// Byte range mark bitmap: one mark bit per byte of a 2^WINDOW_BITS-byte window,
// stored as 32-bit words, one per 32-byte chunk, in a single-port memory.
// Input channel (in_valid/in_stall): command (mark, unmark, test), address and
// byte_count; a transfer happens when in_valid is high and in_stall is low.
// Output channel (out_valid/out_stall): any_marked and done_command, one result
// per request, held stable while out_stall is high.
// Each chunk touched takes a word read, then a modify/write or test.
// A request spans at most 3 chunks (for 64 bytes); a request with no bytes or
// the unused command touches no word and goes straight to the result load.
// One request is in flight at a time; in_stall is high from the transfer until
// the result is loaded into the output register.
// A finished result waits in the output register while out_stall is high; the
// next request's result is held back until that register is free.
// After reset the memory is swept to zero, one word per cycle (all 2048 words at
// the default window); in_stall stays high for that pass.
module byte_range_mark_bitmap_top
    import brmb_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [ADDR_W-1:0]  address,
    input  logic [COUNT_W-1:0] byte_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               any_marked,
    output logic [CMD_W-1:0]   done_command
);

    ctl_t ctl;
    sts_t sts;

    brmb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    brmb_datapath #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .address      (address),
        .byte_count   (byte_count),
        .ctl          (ctl),
        .sts          (sts),
        .any_marked   (any_marked),
        .done_command (done_command)
    );

endmodule

// File: tb/byte_range_mark_bitmap_top_test.sv
`timescale 1ns / 100ps

module byte_range_mark_bitmap_top_test;
    import brmb_pkg::*;

    localparam int WORD_COUNT = (1 << ADDR_W) / CHUNK_BYTES;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
    } range_request_t;

    typedef struct {
        logic             any_marked;
        logic [CMD_W-1:0] done_command;
    } range_answer_t;

    class mark_scoreboard;
        bit [CHUNK_BYTES-1:0] shadow_words [WORD_COUNT];
        range_answer_t        answers [$];
        int                   errors;

        function new();
            foreach (shadow_words[i])
                shadow_words[i] = '0;
            errors = 0;
        endfunction

        // Applies the request to the shadow bitmap and queues its answer.
        function void note_request(range_request_t req);
            int               span;
            logic [ADDR_W-1:0] pos;
            bit               hit;
            range_answer_t    ans;
            span = (req.cnt > MAX_SPAN) ? MAX_SPAN : int'(req.cnt);
            pos  = req.addr;
            hit  = 0;
            if (req.cmd != CMD_NONE)
            begin
                for (int i = 0; i < span; i++)
                begin
                    case (req.cmd)
                        CMD_MARK:   shadow_words[pos[ADDR_W-1:CHUNK_SHIFT]][pos[OFF_W-1:0]] = 1'b1;
                        CMD_UNMARK: shadow_words[pos[ADDR_W-1:CHUNK_SHIFT]][pos[OFF_W-1:0]] = 1'b0;
                        default:    hit |= shadow_words[pos[ADDR_W-1:CHUNK_SHIFT]][pos[OFF_W-1:0]];
                    endcase
                    pos = pos + 1'b1;  // wraps within the window
                end
            end
            ans.any_marked   = (req.cmd == CMD_TEST) && hit;
            ans.done_command = req.cmd;
            answers.push_back(ans);
        endfunction

        function void check_result(logic any_act, logic [CMD_W-1:0] cmd_act);
            range_answer_t ans;
            if (answers.size() == 0)
            begin
                $error("unexpected result: any_marked=%0b done_command=%0d", any_act, cmd_act);
                errors++;
                return;
            end
            ans = answers.pop_front();
            if (any_act !== ans.any_marked)
            begin
                $error("any_marked: expected %0b, actual %0b", ans.any_marked, any_act);
                errors++;
            end
            if (cmd_act !== ans.done_command)
            begin
                $error("done_command: expected %0d, actual %0d", ans.done_command, cmd_act);
                errors++;
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] byte_count;
    logic               out_valid;
    logic               out_stall;
    logic               any_marked;
    logic [CMD_W-1:0]   done_command;

    mark_scoreboard bitmap_sb;
    int             send_idle_pct;
    int             recv_stall_pct;

    byte_range_mark_bitmap_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .byte_count   (byte_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .any_marked   (any_marked),
        .done_command (done_command)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Called at a rising edge; returns at the edge of the transfer.
    task automatic send_request(range_request_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= req.cmd;
        address    <= req.addr;
        byte_count <= req.cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bitmap_sb.note_request(req);
    endtask

    // Mostly well-formed ranges around a few hot regions so marks and tests overlap;
    // the rest scatters over the whole window and odd counts.
    function automatic range_request_t random_request();
        range_request_t req;
        int             pick;
        logic [ADDR_W-1:0] hot_base;
        pick = $urandom_range(99);
        if (pick < 30)
            req.cmd = CMD_MARK;
        else if (pick < 55)
            req.cmd = CMD_UNMARK;
        else if (pick < 95)
            req.cmd = CMD_TEST;
        else
            req.cmd = CMD_NONE;
        case ($urandom_range(3))
            0:       hot_base = 16'h0000;
            1:       hot_base = 16'h4A00;
            2:       hot_base = 16'hFE00;
            default: hot_base = 16'h8000;
        endcase
        if ($urandom_range(99) < 70)
            req.addr = hot_base + ADDR_W'($urandom_range(511));
        else
            req.addr = ADDR_W'($urandom());
        pick = $urandom_range(99);
        if (pick < 5)
            req.cnt = '0;
        else if (pick < 15)
            req.cnt = COUNT_W'($urandom_range(127, MAX_SPAN + 1));
        else
            req.cnt = COUNT_W'($urandom_range(MAX_SPAN, 1));
        return req;
    endfunction

    // Receiver: checks each transfer, stalls at random, and twice holds off long.
    initial
    begin
        int results_seen;
        int hold_left;
        results_seen = 0;
        hold_left    = 0;
        out_stall   <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                bitmap_sb.check_result(any_marked, done_command);
                results_seen++;
                if (results_seen == 400 || results_seen == 1300)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        range_request_t directed [$];
        bitmap_sb      = new();
        send_idle_pct  = 33;
        recv_stall_pct = 67;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        command    <= CMD_MARK;
        address    <= '0;
        byte_count <= '0;

        directed = '{
            '{CMD_MARK,   16'h0000, 7'd1},
            '{CMD_TEST,   16'h0000, 7'd1},
            '{CMD_TEST,   16'h0001, 7'd64},
            '{CMD_MARK,   16'hFFF0, 7'd64},   // wraps into chunks 0 and 1
            '{CMD_TEST,   16'hFFFF, 7'd1},
            '{CMD_TEST,   16'h0020, 7'd32},
            '{CMD_UNMARK, 16'hFFE0, 7'd96},   // saturates to the max span
            '{CMD_TEST,   16'h0000, 7'd64},
            '{CMD_MARK,   16'h0064, 7'd0},    // zero count
            '{CMD_TEST,   16'h0064, 7'd0},
            '{CMD_MARK,   16'h8000, 7'd127},
            '{CMD_TEST,   16'h803F, 7'd1},
            '{CMD_TEST,   16'h8040, 7'd1},
            '{CMD_NONE,   16'h8000, 7'd64},   // unused command leaves the bits alone
            '{CMD_TEST,   16'h8000, 7'd1},
            '{CMD_MARK,   16'h001F, 7'd2},
            '{CMD_TEST,   16'h0020, 7'd1},
            '{CMD_MARK,   16'h7FE1, 7'd64},   // three chunks
            '{CMD_TEST,   16'h8020, 7'd1},
            '{CMD_UNMARK, 16'h0000, 7'd127},
            '{CMD_TEST,   16'h0000, 7'd64},
            '{CMD_MARK,   16'hFFFF, 7'd127},
            '{CMD_TEST,   16'h003E, 7'd2}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);
        repeat (600) send_request(random_request());

        send_idle_pct  = 67;
        recv_stall_pct = 33;
        repeat (600) send_request(random_request());

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (600) send_request(random_request());

        in_valid <= 1'b0;
        while (bitmap_sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (bitmap_sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
